### rtl/ccc_pkg.sv
// Shared types, constants and the arctangent table of the coordinate converter.
`default_nettype none

package ccc_pkg;

	localparam int CORDIC_STEPS = 20;
	localparam int SQRT_STEPS   = 24;
	localparam int CHAIN_LEN    = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

	localparam int XW = 57;
	localparam int ZW = 33;
	localparam int RW = 27;
	localparam int NW = 48;

	localparam logic signed [ZW-1:0] PI_Q28        = 33'sd843314857;
	localparam logic signed [ZW-1:0] TWO_PI_Q28    = 33'sd1686629713;
	localparam logic signed [ZW-1:0] FOUR_PI_Q28   = 33'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q28   = 33'sd421657428;
	localparam logic [29:0]          PI_Q28_U      = 30'd843314857;
	localparam logic [16:0]          DEG_TURN_Q8   = 17'd92160;
	localparam logic [15:0]          DEG_HALF_Q8   = 16'd46080;
	localparam logic [18:0]          RAD_TURN_Q16  = 19'd411775;
	localparam logic signed [30:0]   GAIN_INV_Q30  = 31'sd652032874;

	// Reciprocals for the two unit conversions; the quotient is corrected afterwards.
	localparam logic [31:0] DEG_OUT_RECIP =
		32'(((64'd1 << 46) * 64'd46080) / 64'd843314857);
	localparam logic [38:0] DEG_IN_RECIP =
		39'(((64'd1 << 24) * 64'd843314857) / 64'd46080);

	typedef struct packed {
		logic               op;
		logic               deg;
		logic               origin;
		logic signed [23:0] a;
		logic signed [19:0] b;
	} ccc_item_t;

	typedef struct packed {
		logic signed [24:0] r0;
		logic signed [23:0] r1;
		logic [18:0]        r2;
	} ccc_result_t;

	function automatic logic [28:0] atan_q28(input int idx);
		logic [28:0] v;
		case (idx)
			0:  v = 29'd210828714;
			1:  v = 29'd124459457;
			2:  v = 29'd65760959;
			3:  v = 29'd33381290;
			4:  v = 29'd16755422;
			5:  v = 29'd8385879;
			6:  v = 29'd4193963;
			7:  v = 29'd2097109;
			8:  v = 29'd1048571;
			9:  v = 29'd524287;
			10: v = 29'd262144;
			11: v = 29'd131072;
			12: v = 29'd65536;
			13: v = 29'd32768;
			14: v = 29'd16384;
			15: v = 29'd8192;
			16: v = 29'd4096;
			17: v = 29'd2048;
			18: v = 29'd1024;
			19: v = 29'd512;
			20: v = 29'd256;
			21: v = 29'd128;
			22: v = 29'd64;
			23: v = 29'd32;
			24: v = 29'd16;
			25: v = 29'd8;
			26: v = 29'd4;
			27: v = 29'd2;
			28: v = 29'd1;
			default: v = 29'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/ccc_item_queue.sv
// Two-entry queue that carries classified items from the front end to the back end.
`default_nettype none

module ccc_item_queue import ccc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  ccc_item_t wdata,
	output logic      full,
	input  logic      pop,
	output ccc_item_t rdata,
	output logic      empty
);

	ccc_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

`default_nettype wire

### rtl/ccc_front.sv
// Front end: holds the angle unit register, accepts items and classifies them.
`default_nettype none

module ccc_front import ccc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic               opcode,
	input  logic signed [23:0] first_value,
	input  logic signed [19:0] second_value,
	output logic               iq_push,
	output ccc_item_t          iq_item,
	input  logic               iq_full
);

	logic      deg_q;
	logic      vld_s1;
	ccc_item_t item_s1;
	logic      take;

	assign full    = vld_s1 && iq_full;
	assign take    = push && !full;
	assign iq_push = vld_s1 && !iq_full;
	assign iq_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q  <= 1'b1;
			vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				deg_q <= cfg_wdata;
			end
			if (take) begin
				vld_s1 <= 1'b1;
			end else if (iq_push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.op     <= opcode;
			item_s1.deg    <= deg_q;
			item_s1.origin <= (first_value == 24'sd0) && (second_value == 20'sd0);
			item_s1.a      <= first_value;
			item_s1.b      <= second_value;
		end
	end

endmodule

`default_nettype wire

### rtl/ccc_result_queue.sv
// Two-entry result queue that parts the back end from the consumer.
`default_nettype none

module ccc_result_queue import ccc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ccc_result_t wdata,
	output logic        full,
	input  logic        pop,
	output ccc_result_t rdata,
	output logic        empty
);

	ccc_result_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end

endmodule

`default_nettype wire

### rtl/ccc_back.sv
// Back end: angle reduction, shared CORDIC and square root chain, and output scaling.
`default_nettype none

module ccc_back import ccc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_empty,
	input  ccc_item_t   item,
	output logic        item_pop,
	input  logic        res_full,
	output logic        res_push,
	output ccc_result_t res
);

	localparam int VLD_N = 13 + CHAIN_LEN;

	typedef struct packed {
		logic               op;
		logic               flip;
		logic               origin;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic [RW-1:0]      rem;
		logic [23:0]        root;
		logic [NW-1:0]      n;
	} chain_t;

	logic             en;
	logic [VLD_N-1:0] vld_q;

	// Prologue stages.
	logic signed [23:0]   a_in;
	logic signed [19:0]   b_in;
	logic signed [47:0]   sqa_w;
	logic signed [39:0]   sqb_w;
	logic signed [54:0]   x0_w;
	logic signed [21:0]   u_w;
	logic signed [ZW-1:0] v_w;
	logic signed [ZW-1:0] radm_w;

	logic                 op_s1, deg_s1, org_s1;
	logic signed [23:0]   a_s1;
	logic signed [19:0]   b_s1;
	logic [46:0]          sqa_s1;
	logic [38:0]          sqb_s1;
	logic signed [54:0]   x0_s1;
	logic [20:0]          u_s1;
	logic signed [ZW-1:0] radm_s1;

	logic                 op_s2, deg_s2, org_s2;
	logic signed [23:0]   a_s2;
	logic signed [19:0]   b_s2;
	logic [NW-1:0]        n_s2;
	logic signed [54:0]   x0_s2;
	logic [20:0]          u_s2;
	logic signed [ZW-1:0] radm_s2;
	logic [20:0]          u2_w;

	logic                 op_s3, deg_s3, org_s3;
	logic signed [23:0]   a_s3;
	logic signed [19:0]   b_s3;
	logic [NW-1:0]        n_s3;
	logic signed [54:0]   x0_s3;
	logic [16:0]          d_s3;
	logic signed [ZW-1:0] radm_s3;
	logic [20:0]          u3_w;

	logic                 op_s4, deg_s4, org_s4;
	logic signed [23:0]   a_s4;
	logic signed [19:0]   b_s4;
	logic [NW-1:0]        n_s4;
	logic signed [54:0]   x0_s4;
	logic [55:0]          prod_s4;
	logic [NW-1:0]        nn_s4;
	logic signed [ZW-1:0] radm_s4;

	logic                 op_s5, deg_s5, org_s5;
	logic signed [23:0]   a_s5;
	logic signed [19:0]   b_s5;
	logic [NW-1:0]        n_s5;
	logic signed [54:0]   x0_s5;
	logic [31:0]          qe_s5;
	logic [NW-1:0]        nn_s5;
	logic signed [ZW-1:0] radm_s5;

	logic                 op_s6, deg_s6, org_s6;
	logic signed [23:0]   a_s6;
	logic signed [19:0]   b_s6;
	logic [NW-1:0]        n_s6;
	logic signed [54:0]   x0_s6;
	logic [31:0]          qe_s6;
	logic [NW-1:0]        qm_s6;
	logic [NW-1:0]        nn_s6;
	logic signed [ZW-1:0] radm_s6;

	logic                 op_s7, org_s7;
	logic signed [23:0]   a_s7;
	logic signed [19:0]   b_s7;
	logic [NW-1:0]        n_s7;
	logic signed [54:0]   x0_s7;
	logic signed [ZW-1:0] ang_s7;
	logic signed [NW:0]   r7_w;
	logic signed [ZW-1:0] qs7_w;
	logic signed [ZW-1:0] angd_w;

	chain_t chain_q [CHAIN_LEN+1];
	chain_t init_w;
	logic signed [ZW-1:0] a1_w;

	// Epilogue stages.
	chain_t               cq;
	logic signed [ZW-1:0] zz_w;
	logic                 op_s9, org_s9;
	logic [30:0]          zw_s9;
	logic [23:0]          root_s9;
	logic signed [XW-1:0] xf_s9, yf_s9;

	logic signed [XW-1:0] tx_w, ty_w;
	logic signed [19:0]   fx_w, fy_w;
	logic signed [23:0]   cx_w, cy_w;
	logic [31:0]          rsum_w;
	logic [19:0]          radr_w;

	logic                 op_s10, org_s10;
	logic [63:0]          m_s10;
	logic [NW-1:0]        nd_s10;
	logic [18:0]          rad_s10;
	logic [23:0]          root_s10;
	logic signed [23:0]   cx_s10, cy_s10;

	logic                 op_s11, org_s11;
	logic [17:0]          qe_s11;
	logic [NW-1:0]        nd_s11;
	logic [18:0]          rad_s11;
	logic [23:0]          root_s11;
	logic signed [23:0]   cx_s11, cy_s11;

	logic                 op_s12, org_s12;
	logic [17:0]          qe_s12;
	logic [NW-1:0]        qm_s12;
	logic [NW-1:0]        nd_s12;
	logic [18:0]          rad_s12;
	logic [23:0]          root_s12;
	logic signed [23:0]   cx_s12, cy_s12;

	logic signed [NW:0]   r13_w;
	logic [17:0]          q13_w;
	ccc_result_t          res_w;
	ccc_result_t          res_s13;

	// The whole back end moves together; it halts only when a finished result cannot leave.
	assign en       = !(vld_q[VLD_N-1] && res_full);
	assign item_pop = en && !item_empty;
	assign res_push = en && vld_q[VLD_N-1];
	assign res      = res_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[VLD_N-2:0], !item_empty};
		end
	end

	// Squares, gain product and first angle reduction.
	always_comb begin
		a_in   = item.a;
		b_in   = item.b;
		sqa_w  = a_in * a_in;
		sqb_w  = b_in * b_in;
		x0_w   = a_in * GAIN_INV_Q30;
		u_w    = 22'(b_in) + 22'sd552960;
		v_w    = ZW'(b_in) <<< 12;
		if (v_w >= TWO_PI_Q28) begin
			radm_w = v_w - TWO_PI_Q28;
		end else if (v_w >= 33'sd0) begin
			radm_w = v_w;
		end else if (v_w >= -TWO_PI_Q28) begin
			radm_w = v_w + TWO_PI_Q28;
		end else begin
			radm_w = v_w + FOUR_PI_Q28;
		end
	end

	always_comb begin
		u2_w = u_s1;
		if (u2_w >= 21'd737280) begin
			u2_w = u2_w - 21'd737280;
		end
		if (u2_w >= 21'd368640) begin
			u2_w = u2_w - 21'd368640;
		end
		u3_w = u_s2;
		if (u3_w >= 21'd184320) begin
			u3_w = u3_w - 21'd184320;
		end
		if (u3_w >= 21'(DEG_TURN_Q8)) begin
			u3_w = u3_w - 21'(DEG_TURN_Q8);
		end
	end

	// Quotient estimate may be off by one either way; the remainder repairs it.
	always_comb begin
		r7_w  = $signed({1'b0, nn_s6}) - $signed({1'b0, qm_s6});
		qs7_w = $signed({1'b0, qe_s6});
		if (r7_w < 49'sd0) begin
			angd_w = qs7_w - 33'sd1;
		end else if (r7_w >= $signed({33'd0, DEG_HALF_Q8})) begin
			angd_w = qs7_w + 33'sd1;
		end else begin
			angd_w = qs7_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= item.op;
			deg_s1  <= item.deg;
			org_s1  <= item.origin;
			a_s1    <= a_in;
			b_s1    <= b_in;
			sqa_s1  <= sqa_w[46:0];
			sqb_s1  <= sqb_w[38:0];
			x0_s1   <= x0_w;
			u_s1    <= u_w[20:0];
			radm_s1 <= radm_w;

			op_s2   <= op_s1;
			deg_s2  <= deg_s1;
			org_s2  <= org_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			n_s2    <= NW'(sqa_s1) + NW'(sqb_s1);
			x0_s2   <= x0_s1;
			u_s2    <= u2_w;
			radm_s2 <= radm_s1;

			op_s3   <= op_s2;
			deg_s3  <= deg_s2;
			org_s3  <= org_s2;
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			n_s3    <= n_s2;
			x0_s3   <= x0_s2;
			d_s3    <= u3_w[16:0];
			radm_s3 <= radm_s2;

			op_s4   <= op_s3;
			deg_s4  <= deg_s3;
			org_s4  <= org_s3;
			a_s4    <= a_s3;
			b_s4    <= b_s3;
			n_s4    <= n_s3;
			x0_s4   <= x0_s3;
			prod_s4 <= 56'(d_s3) * 56'(DEG_IN_RECIP) + 56'd8388608;
			nn_s4   <= NW'(d_s3) * NW'(PI_Q28_U) + 48'd23040;
			radm_s4 <= radm_s3;

			op_s5   <= op_s4;
			deg_s5  <= deg_s4;
			org_s5  <= org_s4;
			a_s5    <= a_s4;
			b_s5    <= b_s4;
			n_s5    <= n_s4;
			x0_s5   <= x0_s4;
			qe_s5   <= prod_s4[55:24];
			nn_s5   <= nn_s4;
			radm_s5 <= radm_s4;

			op_s6   <= op_s5;
			deg_s6  <= deg_s5;
			org_s6  <= org_s5;
			a_s6    <= a_s5;
			b_s6    <= b_s5;
			n_s6    <= n_s5;
			x0_s6   <= x0_s5;
			qe_s6   <= qe_s5;
			qm_s6   <= NW'(qe_s5) * NW'(DEG_HALF_Q8);
			nn_s6   <= nn_s5;
			radm_s6 <= radm_s5;

			op_s7   <= op_s6;
			org_s7  <= org_s6;
			a_s7    <= a_s6;
			b_s7    <= b_s6;
			n_s7    <= n_s6;
			x0_s7   <= x0_s6;
			ang_s7  <= deg_s6 ? angd_w : radm_s6;
		end
	end

	// Chain entry: fold the rotation angle into the right half plane, or
	// mirror a vector with negative x for the vectoring pass.
	always_comb begin
		init_w        = '0;
		init_w.op     = op_s7;
		init_w.origin = org_s7;
		init_w.n      = n_s7;
		a1_w          = (ang_s7 > PI_Q28) ? ang_s7 - TWO_PI_Q28 : ang_s7;
		if (op_s7) begin
			init_w.x = XW'(x0_s7);
			if (a1_w > HALF_PI_Q28) begin
				init_w.z    = a1_w - PI_Q28;
				init_w.flip = 1'b1;
			end else if (a1_w < -HALF_PI_Q28) begin
				init_w.z    = a1_w + PI_Q28;
				init_w.flip = 1'b1;
			end else begin
				init_w.z = a1_w;
			end
		end else if (a_s7 < 24'sd0) begin
			init_w.x = -(XW'(a_s7) <<< 24);
			init_w.y = -(XW'(b_s7) <<< 24);
			init_w.z = PI_Q28;
		end else begin
			init_w.x = XW'(a_s7) <<< 24;
			init_w.y = XW'(b_s7) <<< 24;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chain_q[0] <= init_w;
		end
	end

	for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
		localparam logic signed [ZW-1:0] ATAN_K = ZW'(atan_q28(k));
		chain_t nxt;

		always_comb begin
			logic                 up;
			logic signed [XW-1:0] dx;
			logic signed [XW-1:0] dy;
			logic [RW-1:0]        rem_sh;
			logic [RW-1:0]        trial;
			nxt    = chain_q[k];
			up     = chain_q[k].op ? (chain_q[k].z >= 33'sd0) : (chain_q[k].y < 57'sd0);
			dx     = chain_q[k].y >>> k;
			dy     = chain_q[k].x >>> k;
			rem_sh = {chain_q[k].rem[RW-3:0], chain_q[k].n[NW-1:NW-2]};
			trial  = RW'({chain_q[k].root, 2'b01});
			if (k < CORDIC_STEPS) begin
				if (up) begin
					nxt.x = chain_q[k].x - dx;
					nxt.y = chain_q[k].y + dy;
					nxt.z = chain_q[k].z - ATAN_K;
				end else begin
					nxt.x = chain_q[k].x + dx;
					nxt.y = chain_q[k].y - dy;
					nxt.z = chain_q[k].z + ATAN_K;
				end
			end
			if (k < SQRT_STEPS) begin
				nxt.n = {chain_q[k].n[NW-3:0], 2'b00};
				if (rem_sh >= trial) begin
					nxt.rem  = rem_sh - trial;
					nxt.root = {chain_q[k].root[22:0], 1'b1};
				end else begin
					nxt.rem  = rem_sh;
					nxt.root = {chain_q[k].root[22:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				chain_q[k+1] <= nxt;
			end
		end
	end

	// Epilogue.
	always_comb begin
		cq = chain_q[CHAIN_LEN];
		if (cq.z < 33'sd0) begin
			zz_w = cq.z + TWO_PI_Q28;
		end else if (cq.z >= TWO_PI_Q28) begin
			zz_w = cq.z - TWO_PI_Q28;
		end else begin
			zz_w = cq.z;
		end
	end

	// Ceiling to whole units, then saturation to the Q15.8 range.
	always_comb begin
		tx_w = xf_s9 >>> 38;
		ty_w = yf_s9 >>> 38;
		fx_w = tx_w[19:0] + 20'(|xf_s9[37:0]);
		fy_w = ty_w[19:0] + 20'(|yf_s9[37:0]);
		if (fx_w > 20'sd32767) begin
			cx_w = 24'sd8388607;
		end else if (fx_w < -20'sd32768) begin
			cx_w = -24'sd8388608;
		end else begin
			cx_w = {fx_w[15:0], 8'd0};
		end
		if (fy_w > 20'sd32767) begin
			cy_w = 24'sd8388607;
		end else if (fy_w < -20'sd32768) begin
			cy_w = -24'sd8388608;
		end else begin
			cy_w = {fy_w[15:0], 8'd0};
		end
		rsum_w = 32'(zw_s9) + 32'd2048;
		radr_w = rsum_w[31:12];
	end

	always_comb begin
		r13_w = $signed({1'b0, nd_s12}) - $signed({1'b0, qm_s12});
		if (r13_w < 49'sd0) begin
			q13_w = qe_s12 - 18'd1;
		end else if (r13_w >= $signed({19'd0, PI_Q28_U})) begin
			q13_w = qe_s12 + 18'd1;
		end else begin
			q13_w = qe_s12;
		end
		if (op_s12) begin
			res_w.r0 = 25'(cx_s12);
			res_w.r1 = cy_s12;
			res_w.r2 = '0;
		end else begin
			res_w.r0 = $signed({1'b0, root_s12});
			res_w.r1 = (org_s12 || q13_w >= 18'(DEG_TURN_Q8)) ? 24'sd0 :
				$signed({6'd0, q13_w});
			res_w.r2 = org_s12 ? 19'd0 : rad_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s9   <= cq.op;
			org_s9  <= cq.origin;
			zw_s9   <= zz_w[30:0];
			root_s9 <= cq.root + 24'(cq.rem > RW'(cq.root));
			xf_s9   <= cq.flip ? -cq.x : cq.x;
			yf_s9   <= cq.flip ? -cq.y : cq.y;

			op_s10   <= op_s9;
			org_s10  <= org_s9;
			m_s10    <= 64'(zw_s9) * 64'(DEG_OUT_RECIP) + (64'd1 << 45);
			nd_s10   <= NW'(zw_s9) * NW'(DEG_HALF_Q8) + 48'd421657428;
			rad_s10  <= (radr_w >= 20'(RAD_TURN_Q16)) ? 19'd0 : radr_w[18:0];
			root_s10 <= root_s9;
			cx_s10   <= cx_w;
			cy_s10   <= cy_w;

			op_s11   <= op_s10;
			org_s11  <= org_s10;
			qe_s11   <= m_s10[63:46];
			nd_s11   <= nd_s10;
			rad_s11  <= rad_s10;
			root_s11 <= root_s10;
			cx_s11   <= cx_s10;
			cy_s11   <= cy_s10;

			op_s12   <= op_s11;
			org_s12  <= org_s11;
			qe_s12   <= qe_s11;
			qm_s12   <= NW'(qe_s11) * NW'(PI_Q28_U);
			nd_s12   <= nd_s11;
			rad_s12  <= rad_s11;
			root_s12 <= root_s11;
			cx_s12   <= cx_s11;
			cy_s12   <= cy_s11;

			res_s13 <= res_w;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result transfer into a full queue");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(res_s13) && vld_q[VLD_N-1])
		else $error("waiting result changed during a stall");

	a_rad_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[VLD_N-1] |-> res_s13.r2 < RAD_TURN_Q16)
		else $error("radian angle outside one turn");
`endif

endmodule

`default_nettype wire

### rtl/complex_coordinate_converter.sv
// Top level of the complex coordinate converter.
`default_nettype none

// Converts rectangular x, y to magnitude and angle (degrees and radians), or a
// magnitude and angle back to x, y rounded up to whole units. One item is
// accepted in every clock cycle while full is low; each result passes the
// front register, item queue, prologue, the shared CORDIC and 24-step square
// root chain and the epilogue; the fully pipelined back end sets the rate.
// full rises only when the result queue backs up. The angle unit register
// applies to polar inputs and should be written while no item is in flight.
module complex_coordinate_converter import ccc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic               opcode,
	input  logic signed [23:0] first_value,
	input  logic signed [19:0] second_value,
	output logic               empty,
	input  logic               pop,
	output logic signed [24:0] first_result,
	output logic signed [23:0] second_result,
	output logic [18:0]        angle_radians
);

	logic        iq_push, iq_full, iq_pop, iq_empty;
	ccc_item_t   iq_wdata, iq_rdata;
	logic        rq_push, rq_full;
	ccc_result_t rq_wdata, rq_rdata;

	ccc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.first_value  (first_value),
		.second_value (second_value),
		.iq_push      (iq_push),
		.iq_item      (iq_wdata),
		.iq_full      (iq_full)
	);

	ccc_item_queue u_item_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (iq_push),
		.wdata  (iq_wdata),
		.full   (iq_full),
		.pop    (iq_pop),
		.rdata  (iq_rdata),
		.empty  (iq_empty)
	);

	ccc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_empty (iq_empty),
		.item       (iq_rdata),
		.item_pop   (iq_pop),
		.res_full   (rq_full),
		.res_push   (rq_push),
		.res        (rq_wdata)
	);

	ccc_result_queue u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign first_result  = rq_rdata.r0;
	assign second_result = rq_rdata.r1;
	assign angle_radians = rq_rdata.r2;

endmodule

`default_nettype wire
